// ===== sv/slesc_pkg.sv =====
// ----------------------------------------------------------------------------
// String literal escape decoder package
// Error codes, character constants and the hex digit decode shared by the
// decoder unit.
// ----------------------------------------------------------------------------
package slesc_pkg;

    // Error codes reported with every result item.
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_ESCAPE   = 3'd1;
    localparam logic [2:0] ERR_HEX      = 3'd2;
    localparam logic [2:0] ERR_UNICODE  = 3'd3;
    localparam logic [2:0] ERR_UNQUOTED = 3'd4;

    // Characters recognised in the literal.
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_APOS      = 8'h27;
    localparam logic [7:0] CH_QUESTION  = 8'h3f;
    localparam logic [7:0] CH_BACKSLASH = 8'h5c;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_A         = 8'h61;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_N         = 8'h6e;
    localparam logic [7:0] CH_V         = 8'h76;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] CH_U         = 8'h75;

    // Decoded control bytes.
    localparam logic [7:0] BYTE_NUL = 8'h00;
    localparam logic [7:0] BYTE_BEL = 8'h07;
    localparam logic [7:0] BYTE_BS  = 8'h08;
    localparam logic [7:0] BYTE_HT  = 8'h09;
    localparam logic [7:0] BYTE_LF  = 8'h0a;
    localparam logic [7:0] BYTE_VT  = 8'h0b;
    localparam logic [7:0] BYTE_FF  = 8'h0c;
    localparam logic [7:0] BYTE_CR  = 8'h0d;

    // Result of decoding one hex digit.
    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_digit_t;

    // Decode one character as a hex digit; letters of either case are 10..15.
    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t r;
        r.ok    = 1'b0;
        r.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.ok    = 1'b1;
            r.value = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r.ok    = 1'b1;
            r.value = c[3:0] + 4'd9;
        end
        return r;
    endfunction

endpackage

// ===== sv/string_literal_escape_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// String literal escape decoder unit
// Decodes a double-quoted literal one character per item, including the
// escapes \0 \a \b \t \n \v \f \r \" \' \? \\ and \xHH, with sticky errors.
// ----------------------------------------------------------------------------
// An accepted item's result is in the output register in the following cycle.
// Throughput: one item per cycle; the single result register is refilled in the
// same cycle that it is drained, so only a held result stalls the input.
// Reset: synchronous, active low; the decoder waits for an opening quote with
// no error recorded and the result register empty.
module string_literal_escape_decoder_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_code,
    input  logic       s_is_first,
    input  logic       s_is_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_byte_valid,
    output logic       m_done_res,
    output logic [2:0] m_error_code
);

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_BODY = 3'd1,
        MODE_ESC  = 3'd2,
        MODE_HEX1 = 3'd3,
        MODE_HEX2 = 3'd4,
        MODE_ERR  = 3'd5
    } mode_t;

    mode_t      mode_reg, mode_next;
    logic [3:0] nibble_reg, nibble_next;
    logic [2:0] err_reg, err_next;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg, byte_next;
    logic       byte_valid_reg, bvalid_next;
    logic       done_reg;
    logic [2:0] out_err_reg;
    logic       accept;
    slesc_pkg::hex_digit_t hex;

    // The result register accepts a new item whenever it is empty or draining.
    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign hex     = slesc_pkg::hex_decode(s_char_code);

    // Decode of one character against the current mode. A failure keeps the
    // first error and parks the decoder until the closing or next first item.
    always_comb begin
        mode_next   = mode_reg;
        nibble_next = nibble_reg;
        err_next    = err_reg;
        byte_next   = 8'd0;
        bvalid_next = 1'b0;
        if (s_is_first) begin
            nibble_next = 4'd0;
            if (s_char_code == slesc_pkg::CH_QUOTE) begin
                err_next  = slesc_pkg::ERR_NONE;
                mode_next = MODE_BODY;
            end else begin
                err_next  = slesc_pkg::ERR_UNQUOTED;
                mode_next = MODE_ERR;
            end
        end else if (s_is_last) begin
            unique case (mode_reg)
                MODE_BODY, MODE_ERR: begin
                end
                MODE_ESC: begin
                    if (err_reg == slesc_pkg::ERR_NONE) err_next = slesc_pkg::ERR_ESCAPE;
                    mode_next = MODE_ERR;
                end
                MODE_HEX1, MODE_HEX2: begin
                    if (err_reg == slesc_pkg::ERR_NONE) err_next = slesc_pkg::ERR_HEX;
                    mode_next = MODE_ERR;
                end
                default: begin
                    if (err_reg == slesc_pkg::ERR_NONE) err_next = slesc_pkg::ERR_UNQUOTED;
                    mode_next = MODE_ERR;
                end
            endcase
        end else begin
            unique case (mode_reg)
                MODE_BODY: begin
                    if (s_char_code == slesc_pkg::CH_BACKSLASH) begin
                        mode_next = MODE_ESC;
                    end else begin
                        byte_next   = s_char_code;
                        bvalid_next = 1'b1;
                    end
                end
                MODE_ESC: begin
                    mode_next   = MODE_BODY;
                    bvalid_next = 1'b1;
                    unique case (s_char_code)
                        slesc_pkg::CH_ZERO:      byte_next = slesc_pkg::BYTE_NUL;
                        slesc_pkg::CH_A:         byte_next = slesc_pkg::BYTE_BEL;
                        slesc_pkg::CH_B:         byte_next = slesc_pkg::BYTE_BS;
                        slesc_pkg::CH_T:         byte_next = slesc_pkg::BYTE_HT;
                        slesc_pkg::CH_N:         byte_next = slesc_pkg::BYTE_LF;
                        slesc_pkg::CH_V:         byte_next = slesc_pkg::BYTE_VT;
                        slesc_pkg::CH_F:         byte_next = slesc_pkg::BYTE_FF;
                        slesc_pkg::CH_R:         byte_next = slesc_pkg::BYTE_CR;
                        slesc_pkg::CH_QUOTE:     byte_next = slesc_pkg::CH_QUOTE;
                        slesc_pkg::CH_APOS:      byte_next = slesc_pkg::CH_APOS;
                        slesc_pkg::CH_QUESTION:  byte_next = slesc_pkg::CH_QUESTION;
                        slesc_pkg::CH_BACKSLASH: byte_next = slesc_pkg::CH_BACKSLASH;
                        slesc_pkg::CH_X: begin
                            bvalid_next = 1'b0;
                            mode_next   = MODE_HEX1;
                        end
                        slesc_pkg::CH_U: begin
                            bvalid_next = 1'b0;
                            if (err_reg == slesc_pkg::ERR_NONE) err_next = slesc_pkg::ERR_UNICODE;
                            mode_next = MODE_ERR;
                        end
                        default: begin
                            bvalid_next = 1'b0;
                            if (err_reg == slesc_pkg::ERR_NONE) err_next = slesc_pkg::ERR_ESCAPE;
                            mode_next = MODE_ERR;
                        end
                    endcase
                end
                MODE_HEX1: begin
                    if (hex.ok) begin
                        nibble_next = hex.value;
                        mode_next   = MODE_HEX2;
                    end else begin
                        if (err_reg == slesc_pkg::ERR_NONE) err_next = slesc_pkg::ERR_HEX;
                        mode_next = MODE_ERR;
                    end
                end
                MODE_HEX2: begin
                    if (hex.ok) begin
                        byte_next   = {nibble_reg, hex.value};
                        bvalid_next = 1'b1;
                        mode_next   = MODE_BODY;
                    end else begin
                        if (err_reg == slesc_pkg::ERR_NONE) err_next = slesc_pkg::ERR_HEX;
                        mode_next = MODE_ERR;
                    end
                end
                MODE_ERR: begin
                end
                default: begin
                    if (err_reg == slesc_pkg::ERR_NONE) err_next = slesc_pkg::ERR_UNQUOTED;
                    mode_next = MODE_ERR;
                end
            endcase
        end
    end

    // Decoder state and the result register. The closing item returns the
    // decoder to idle once its result has been captured.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_IDLE;
            nibble_reg    <= 4'd0;
            err_reg       <= slesc_pkg::ERR_NONE;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                out_valid_reg  <= 1'b1;
                out_byte_reg   <= byte_next;
                byte_valid_reg <= bvalid_next;
                done_reg       <= s_is_last;
                out_err_reg    <= err_next;
                if (s_is_last) begin
                    mode_reg   <= MODE_IDLE;
                    nibble_reg <= 4'd0;
                    err_reg    <= slesc_pkg::ERR_NONE;
                end else begin
                    mode_reg   <= mode_next;
                    nibble_reg <= nibble_next;
                    err_reg    <= err_next;
                end
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_out_byte   = out_byte_reg;
    assign m_byte_valid = byte_valid_reg;
    assign m_done_res   = done_reg;
    assign m_error_code = out_err_reg;

    // A decoded byte is only ever delivered while the literal is free of errors.
    a_byte_no_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_byte_valid |-> m_error_code == slesc_pkg::ERR_NONE)
        else $error("decoded byte delivered with an error recorded");

    // The closing item never yields a byte.
    a_done_no_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> !m_byte_valid)
        else $error("closing item produced a byte");

    // The error mode and a recorded error always go together.
    a_err_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_ERR) == (err_reg != slesc_pkg::ERR_NONE))
        else $error("error mode and recorded error disagree");

    // After a closing item the decoder waits for a fresh opening quote.
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_is_last |=> mode_reg == MODE_IDLE && err_reg == slesc_pkg::ERR_NONE)
        else $error("decoder not idle after closing item");

endmodule

// ===== sim/escape_decode_checker.sv =====
// ----------------------------------------------------------------------------
// Escape decoder result checker
// Watches both channels of the string literal escape decoder, predicts one
// result item for every accepted character item and compares the results
// field by field, in order, against what the decoder delivers.
// ----------------------------------------------------------------------------
module escape_decode_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_char_code,
    input  logic       s_is_first,
    input  logic       s_is_last,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_out_byte,
    input  logic       m_byte_valid,
    input  logic       m_done_res,
    input  logic [2:0] m_error_code,
    output int         mismatch_count,
    output int         pending_count
);

    // Position of the predictor within a literal.
    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_BODY,
        MODE_ESC,
        MODE_HEX1,
        MODE_HEX2,
        MODE_ERR
    } decode_mode_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       done_res;
        logic [2:0] error_code;
    } decoded_item_t;

    decode_mode_t  mode;
    logic [3:0]    hi_nibble;
    logic [2:0]    first_error;
    decoded_item_t decoded_q[$];

    // Value of one hex digit; letters of either case count 10 to 15.
    function automatic logic hex_digit(input logic [7:0] c, output logic [3:0] v);
        logic [7:0] d;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h61 + 8'd10;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h41 + 8'd10;
        end else begin
            return 1'b0;
        end
        v = d[3:0];
        return 1'b1;
    endfunction

    // Only the first error of a literal is kept.
    task automatic record_error(input logic [2:0] code);
        if (first_error == slesc_pkg::ERR_NONE) first_error = code;
        mode = MODE_ERR;
    endtask

    // Advance the decode state by one character and build its result item.
    task automatic decode_char(input logic [7:0] c, input logic first, input logic last,
                               output decoded_item_t r);
        logic [3:0] nib;
        logic       ok;
        r = '0;
        if (first) begin
            first_error = slesc_pkg::ERR_NONE;
            hi_nibble   = 4'd0;
            if (c == slesc_pkg::CH_QUOTE) mode = MODE_BODY;
            else record_error(slesc_pkg::ERR_UNQUOTED);
        end else if (last) begin
            // The closing item never yields a byte, but it may cut off an escape.
            case (mode)
                MODE_BODY, MODE_ERR: ;
                MODE_ESC:             record_error(slesc_pkg::ERR_ESCAPE);
                MODE_HEX1, MODE_HEX2: record_error(slesc_pkg::ERR_HEX);
                default:              record_error(slesc_pkg::ERR_UNQUOTED);
            endcase
        end else begin
            case (mode)
                MODE_BODY: begin
                    if (c == slesc_pkg::CH_BACKSLASH) begin
                        mode = MODE_ESC;
                    end else begin
                        r.out_byte   = c;
                        r.byte_valid = 1'b1;
                    end
                end
                MODE_ESC: begin
                    mode         = MODE_BODY;
                    r.byte_valid = 1'b1;
                    case (c)
                        slesc_pkg::CH_ZERO:      r.out_byte = slesc_pkg::BYTE_NUL;
                        slesc_pkg::CH_A:         r.out_byte = slesc_pkg::BYTE_BEL;
                        slesc_pkg::CH_B:         r.out_byte = slesc_pkg::BYTE_BS;
                        slesc_pkg::CH_T:         r.out_byte = slesc_pkg::BYTE_HT;
                        slesc_pkg::CH_N:         r.out_byte = slesc_pkg::BYTE_LF;
                        slesc_pkg::CH_V:         r.out_byte = slesc_pkg::BYTE_VT;
                        slesc_pkg::CH_F:         r.out_byte = slesc_pkg::BYTE_FF;
                        slesc_pkg::CH_R:         r.out_byte = slesc_pkg::BYTE_CR;
                        slesc_pkg::CH_QUOTE:     r.out_byte = slesc_pkg::CH_QUOTE;
                        slesc_pkg::CH_APOS:      r.out_byte = slesc_pkg::CH_APOS;
                        slesc_pkg::CH_QUESTION:  r.out_byte = slesc_pkg::CH_QUESTION;
                        slesc_pkg::CH_BACKSLASH: r.out_byte = slesc_pkg::CH_BACKSLASH;
                        slesc_pkg::CH_X: begin
                            r.byte_valid = 1'b0;
                            mode         = MODE_HEX1;
                        end
                        slesc_pkg::CH_U: begin
                            r.byte_valid = 1'b0;
                            record_error(slesc_pkg::ERR_UNICODE);
                        end
                        default: begin
                            r.byte_valid = 1'b0;
                            record_error(slesc_pkg::ERR_ESCAPE);
                        end
                    endcase
                end
                MODE_HEX1: begin
                    ok = hex_digit(c, nib);
                    if (!ok) begin
                        record_error(slesc_pkg::ERR_HEX);
                    end else begin
                        hi_nibble = nib;
                        mode      = MODE_HEX2;
                    end
                end
                MODE_HEX2: begin
                    ok = hex_digit(c, nib);
                    if (!ok) begin
                        record_error(slesc_pkg::ERR_HEX);
                    end else begin
                        r.out_byte   = {hi_nibble, nib};
                        r.byte_valid = 1'b1;
                        mode         = MODE_BODY;
                    end
                end
                MODE_ERR: ;
                default:  record_error(slesc_pkg::ERR_UNQUOTED);
            endcase
        end
        r.done_res   = last;
        r.error_code = first_error;
        // A finished literal leaves the decoder idle and clean.
        if (last) begin
            mode        = MODE_IDLE;
            hi_nibble   = 4'd0;
            first_error = slesc_pkg::ERR_NONE;
        end
    endtask

    task automatic check_field(input string field, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want_v,
                     got_v);
            mismatch_count++;
        end
    endtask

    // Compare results first, then queue the prediction for a newly taken item.
    always @(posedge aclk) begin : monitor
        decoded_item_t want;
        if (!aresetn) begin
            mode        = MODE_IDLE;
            hi_nibble   = 4'd0;
            first_error = slesc_pkg::ERR_NONE;
            decoded_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (decoded_q.size() == 0) begin
                    $display("%0t: unexpected result item: expected none, actual %h %b %b %0d",
                             $time, m_out_byte, m_byte_valid, m_done_res, m_error_code);
                    mismatch_count++;
                end else begin
                    want = decoded_q.pop_front();
                    check_field("out_byte", want.out_byte, m_out_byte);
                    check_field("byte_valid", want.byte_valid, m_byte_valid);
                    check_field("done_res", want.done_res, m_done_res);
                    check_field("error_code", want.error_code, m_error_code);
                end
            end
            if (s_valid && s_ready) begin
                decode_char(s_char_code, s_is_first, s_is_last, want);
                decoded_q = {decoded_q, want};
            end
        end
        pending_count = decoded_q.size();
    end

endmodule

// ===== sim/tb_string_literal_escape_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// String literal escape decoder unit testbench
// Feeds directed literals covering every error code, then a long stream of
// mostly well-formed random literals mixed with stray items, with
// random idling on both channels, a long result hold-off and a full drain.
// ----------------------------------------------------------------------------
module tb_string_literal_escape_decoder_unit;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 6;
    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 160;
    localparam int RANDOM_ITEMS    = 750;
    localparam int DRAIN_CYCLES    = 8;

    localparam logic [7:0] SIMPLE_ESCAPES [12] = '{
        slesc_pkg::CH_ZERO, slesc_pkg::CH_A, slesc_pkg::CH_B, slesc_pkg::CH_T,
        slesc_pkg::CH_N, slesc_pkg::CH_V, slesc_pkg::CH_F, slesc_pkg::CH_R,
        slesc_pkg::CH_QUOTE, slesc_pkg::CH_APOS, slesc_pkg::CH_QUESTION,
        slesc_pkg::CH_BACKSLASH
    };

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [7:0] s_char_code = 8'd0;
    logic       s_is_first  = 1'b0;
    logic       s_is_last   = 1'b0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_byte_valid;
    logic       m_done_res;
    logic [2:0] m_error_code;

    int mismatch_count;
    int pending_count;
    int items_sent;
    int quiet_cycles;
    bit idle_on      = 1'b1;
    bit hold_request = 1'b0;

    always #CLK_HALF aclk = ~aclk;

    string_literal_escape_decoder_unit u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_char_code  (s_char_code),
        .s_is_first   (s_is_first),
        .s_is_last    (s_is_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_byte_valid (m_byte_valid),
        .m_done_res   (m_done_res),
        .m_error_code (m_error_code)
    );

    escape_decode_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_code    (s_char_code),
        .s_is_first     (s_is_first),
        .s_is_last      (s_is_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_byte_valid   (m_byte_valid),
        .m_done_res     (m_done_res),
        .m_error_code   (m_error_code),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // Watchdog: ends the run when neither channel moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_string_literal_escape_decoder_unit failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: random back-pressure, with one long hold-off on request.
    initial begin : receiver
        bit hold_served;
        hold_served = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request && !hold_served) begin
                hold_served = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end
            if (idle_on) m_ready <= ($urandom_range(99) >= 30);
            else m_ready <= 1'b1;
        end
    end

    // Offer one character item and wait until the decoder takes it.
    task automatic send_char(input logic [7:0] c, input logic first, input logic last);
        // Each cycle before the item is idle with a chance of three in ten.
        while (idle_on && $urandom_range(99) < 30) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_char_code <= c;
        s_is_first  <= first;
        s_is_last   <= last;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Stop offering and wait until every outstanding result has come back.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_count != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] random_hex_char();
        int v;
        v = $urandom_range(15);
        if (v < 10) return 8'h30 + 8'(v);
        return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(v - 10);
    endfunction

    // One piece of a literal body: a plain character, an escape or a fault.
    task automatic send_body_token();
        int         pick;
        logic [7:0] c;
        pick = $urandom_range(99);
        if (pick < 45) begin
            c = 8'($urandom_range(255));
            if (c == slesc_pkg::CH_BACKSLASH) c = c ^ 8'h01;
            send_char(c, 1'b0, 1'b0);
        end else if (pick < 75) begin
            send_char(slesc_pkg::CH_BACKSLASH, 1'b0, 1'b0);
            send_char(SIMPLE_ESCAPES[4'($urandom_range(11))], 1'b0, 1'b0);
        end else if (pick < 92) begin
            send_char(slesc_pkg::CH_BACKSLASH, 1'b0, 1'b0);
            send_char(slesc_pkg::CH_X, 1'b0, 1'b0);
            send_char(random_hex_char(), 1'b0, 1'b0);
            send_char(random_hex_char(), 1'b0, 1'b0);
        end else if (pick < 95) begin
            // Unknown or unicode escape.
            send_char(slesc_pkg::CH_BACKSLASH, 1'b0, 1'b0);
            send_char($urandom_range(1) ? slesc_pkg::CH_U : 8'($urandom_range(255)),
                      1'b0, 1'b0);
        end else begin
            // Hex escape with a random, usually bad, digit in either place.
            send_char(slesc_pkg::CH_BACKSLASH, 1'b0, 1'b0);
            send_char(slesc_pkg::CH_X, 1'b0, 1'b0);
            if ($urandom_range(1)) send_char(random_hex_char(), 1'b0, 1'b0);
            send_char(8'($urandom_range(255)), 1'b0, 1'b0);
        end
    endtask

    // A whole literal: opening quote, body, sometimes a cut-off escape, close.
    task automatic send_literal();
        int n;
        n = $urandom_range(12);
        send_char(slesc_pkg::CH_QUOTE, 1'b1, 1'b0);
        repeat (n) send_body_token();
        if ($urandom_range(99) < 6) begin
            send_char(slesc_pkg::CH_BACKSLASH, 1'b0, 1'b0);
            if ($urandom_range(1)) begin
                send_char(slesc_pkg::CH_X, 1'b0, 1'b0);
                if ($urandom_range(1)) send_char(random_hex_char(), 1'b0, 1'b0);
            end
        end
        send_char(($urandom_range(99) < 80) ? slesc_pkg::CH_QUOTE : 8'($urandom_range(255)),
                  1'b0, 1'b1);
    endtask

    // Stimulus and verdict.
    initial begin : stimulus
        int  random_start;
        int  done_count;
        bit  hold_done;
        bit  drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // One-character literals, good and unquoted, and a stray body item.
        send_char(slesc_pkg::CH_QUOTE, 1'b1, 1'b1);
        send_char(8'h41, 1'b1, 1'b1);
        send_char(8'h41, 1'b0, 1'b0);
        send_char(slesc_pkg::CH_QUOTE, 1'b0, 1'b1);
        // Extreme plain bytes, hex of both cases, then a unicode escape.
        send_char(slesc_pkg::CH_QUOTE, 1'b1, 1'b0);
        send_char(8'h00, 1'b0, 1'b0);
        send_char(8'hff, 1'b0, 1'b0);
        send_char(slesc_pkg::CH_BACKSLASH, 1'b0, 1'b0);
        send_char(slesc_pkg::CH_X, 1'b0, 1'b0);
        send_char(8'h66, 1'b0, 1'b0);
        send_char(8'h46, 1'b0, 1'b0);
        send_char(slesc_pkg::CH_BACKSLASH, 1'b0, 1'b0);
        send_char(slesc_pkg::CH_U, 1'b0, 1'b0);
        send_char(slesc_pkg::CH_QUOTE, 1'b0, 1'b1);
        // Backslash cut off by a restart, then by the closing quote.
        send_char(slesc_pkg::CH_QUOTE, 1'b1, 1'b0);
        send_char(slesc_pkg::CH_BACKSLASH, 1'b0, 1'b0);
        send_char(slesc_pkg::CH_QUOTE, 1'b1, 1'b0);
        send_char(slesc_pkg::CH_BACKSLASH, 1'b0, 1'b0);
        send_char(slesc_pkg::CH_QUOTE, 1'b0, 1'b1);
        // Hex escape cut off after one digit; closing character is not a quote.
        send_char(slesc_pkg::CH_QUOTE, 1'b1, 1'b0);
        send_char(slesc_pkg::CH_BACKSLASH, 1'b0, 1'b0);
        send_char(slesc_pkg::CH_X, 1'b0, 1'b0);
        send_char(8'h39, 1'b0, 1'b0);
        send_char(8'hff, 1'b0, 1'b1);

        // Random literals with occasional stray items.
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            done_count = items_sent - random_start;
            idle_on    = !(done_count >= 100 && done_count < 260);
            if (!hold_done && done_count >= 300) begin
                hold_done    = 1'b1;
                hold_request = 1'b1;
            end
            if (!drain_done && done_count >= 500) begin
                drain_done = 1'b1;
                drain_results();
            end
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(3, 1))
                    send_char(8'($urandom_range(255)), 1'($urandom_range(1)),
                              1'($urandom_range(1)));
            end else begin
                send_literal();
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("tb_string_literal_escape_decoder_unit passed");
        end else begin
            $display("tb_string_literal_escape_decoder_unit failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/slesc_pkg.sv
sv/string_literal_escape_decoder_unit.sv
sim/escape_decode_checker.sv
sim/tb_string_literal_escape_decoder_unit.sv
